>>> rtl/wtsp_pkg.sv
// shared constants and types for the world-to-screen projection block
package wtsp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    // clip word width is CLIP_BASE - FRAC_BITS; a product shifted down plus two bits of growth
    localparam int CLIP_BASE = 66;
    // quotient bits needed before saturation
    localparam int QBITS = 33;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_W      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_BIAS      = 3'd4;

    localparam logic [13:0] VIEW_WIDTH_RST  = 14'd1920;
    localparam logic [13:0] VIEW_HEIGHT_RST = 14'd1080;
    localparam logic [30:0] NEAR_W_RST      = 31'd6554;
    localparam logic        OUT_MODE_RST    = 1'b1;
    localparam logic [31:0] Y_BIAS_RST      = 32'd1311;

    localparam logic MODE_NORM  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef logic signed [31:0] t_q32;

endpackage

>>> rtl/wtsp_pt_if.sv
// input channel: matrix loads and points to project
interface wtsp_pt_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, op, coef_index, coef_value, pos_x, pos_y, pos_z,
                    input ready);
    modport sink   (input valid, op, coef_index, coef_value, pos_x, pos_y, pos_z,
                    output ready);
endinterface

>>> rtl/wtsp_res_if.sv
// output channel: projected screen position
interface wtsp_res_if;
    logic               valid;
    logic               ready;
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;

    modport source (output valid, visible, screen_x, screen_y, input ready);
    modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

>>> rtl/wtsp_matrix.sv
// matrix store and the product stage
module wtsp_matrix
    import wtsp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_accept,
    input  logic               i_op,
    input  logic [3:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               o_valid,
    output logic signed [63:0] o_prod [0:8],
    output logic signed [31:0] o_offs [0:2]
);

    logic signed [31:0] r_mat [0:15];
    logic               r_valid;
    logic signed [63:0] r_prod [0:8];
    logic signed [31:0] r_offs [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_mat[i] <= '0;
        end else if (i_accept && i_op == OP_LOAD) begin
            r_mat[i_coef_index] <= i_coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_accept && i_op == OP_PROJECT;
        end
    end

    // rows 0, 1 and 3; row 2 is not used
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod[0] <= i_pos_x * r_mat[0];
            r_prod[1] <= i_pos_y * r_mat[1];
            r_prod[2] <= i_pos_z * r_mat[2];
            r_prod[3] <= i_pos_x * r_mat[4];
            r_prod[4] <= i_pos_y * r_mat[5];
            r_prod[5] <= i_pos_z * r_mat[6];
            r_prod[6] <= i_pos_x * r_mat[12];
            r_prod[7] <= i_pos_y * r_mat[13];
            r_prod[8] <= i_pos_z * r_mat[14];
            r_offs[0] <= r_mat[3];
            r_offs[1] <= r_mat[7];
            r_offs[2] <= r_mat[15];
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_offs  = r_offs;

endmodule

>>> rtl/wtsp_clip.sv
// clip sums for X, Y and W
module wtsp_clip
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [63:0]          i_prod [0:8],
    input  logic signed [31:0]          i_offs [0:2],
    output logic                        o_valid,
    output logic signed [CLIP_BASE-FRAC_BITS-1:0] o_cx,
    output logic signed [CLIP_BASE-FRAC_BITS-1:0] o_cy,
    output logic signed [CLIP_BASE-FRAC_BITS-1:0] o_cw
);

    localparam int CW = CLIP_BASE - FRAC_BITS;

    logic signed [CW-1:0] sh [0:8];
    logic signed [CW-1:0] n_c [0:2];
    logic signed [CW-1:0] r_c [0:2];
    logic                 r_valid;

    // arithmetic shift floors each product
    always_comb begin
        for (int i = 0; i < 9; i++) sh[i] = CW'(i_prod[i] >>> FRAC_BITS);
        for (int r = 0; r < 3; r++) begin
            n_c[r] = sh[3*r] + sh[3*r+1] + sh[3*r+2] + CW'(i_offs[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= n_c;
        end
    end

    assign o_valid = r_valid;
    assign o_cx    = r_c[0];
    assign o_cy    = r_c[1];
    assign o_cw    = r_c[2];

endmodule

>>> rtl/wtsp_div.sv
// pipelined restoring divider, one quotient bit a stage, with saturation
module wtsp_div
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [CLIP_BASE-FRAC_BITS-1:0] i_num,
    input  logic [CLIP_BASE-FRAC_BITS-1:0]        i_den,
    output t_q32                                  o_quo
);

    localparam int CW = CLIP_BASE - FRAC_BITS;
    localparam int NW = CW + FRAC_BITS;

    logic [CW-1:0]    mag;
    logic [NW-1:0]    big;
    logic [CW-1:0]    top;

    logic [CW:0]      r_rem  [0:QBITS];
    logic [QBITS-1:0] r_low  [0:QBITS];
    logic [QBITS-1:0] r_quo  [0:QBITS];
    logic [CW-1:0]    r_den  [0:QBITS];
    logic             r_neg  [0:QBITS];
    logic             r_zero [0:QBITS];
    logic             r_ovf  [0:QBITS];

    always_comb begin
        mag = i_num[CW-1] ? CW'(-i_num) : CW'(i_num);
        big = {mag, FRAC_BITS'(0)};
        top = CW'(big[NW-1:QBITS]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {1'b0, top};
            r_low[0]  <= big[QBITS-1:0];
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_neg[0]  <= i_num[CW-1];
            r_zero[0] <= mag == '0;
            // quotient would need more than QBITS bits
            r_ovf[0]  <= top >= i_den;
        end
    end

    for (genvar k = 0; k < QBITS; k++) begin : g_step
        logic [CW:0] trial;
        logic        ge;
        assign trial = {r_rem[k][CW-1:0], r_low[k][QBITS-1]};
        assign ge    = trial >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= ge ? trial - {1'b0, r_den[k]} : trial;
                r_low[k+1]  <= {r_low[k][QBITS-2:0], 1'b0};
                r_quo[k+1]  <= {r_quo[k][QBITS-2:0], ge};
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_zero[k+1] <= r_zero[k];
                r_ovf[k+1]  <= r_ovf[k];
            end
        end
    end

    always_comb begin
        if (r_zero[QBITS]) begin
            o_quo = '0;
        end else if (r_ovf[QBITS]) begin
            o_quo = r_neg[QBITS] ? t_q32'(32'h8000_0000) : t_q32'(32'h7FFF_FFFF);
        end else if (r_neg[QBITS]) begin
            o_quo = (r_quo[QBITS] > QBITS'(33'h0_8000_0000)) ? t_q32'(32'h8000_0000)
                  : t_q32'(32'(-r_quo[QBITS]));
        end else begin
            o_quo = (r_quo[QBITS] > QBITS'(33'h0_7FFF_FFFF)) ? t_q32'(32'h7FFF_FFFF)
                  : t_q32'(r_quo[QBITS][31:0]);
        end
    end

endmodule

>>> rtl/wtsp_viewport.sv
// viewport scaling or y bias, product stage then sum and saturate
module wtsp_viewport
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_q32               i_nx,
    input  t_q32               i_ny,
    input  logic [13:0]        i_view_width,
    input  logic [13:0]        i_view_height,
    input  logic               i_mode,
    input  logic signed [31:0] i_y_bias,
    output t_q32               o_sx,
    output t_q32               o_sy
);

    localparam int VW = 50;

    logic signed [47:0] r_px;
    logic signed [47:0] r_py;
    t_q32               r_nx;
    t_q32               r_ny;
    logic signed [15:0] kx;
    logic signed [15:0] ky;
    logic signed [VW-1:0] sum_x;
    logic signed [VW-1:0] sum_y;
    logic signed [VW-1:0] half_x;
    logic signed [VW-1:0] half_y;
    logic signed [32:0]   by;

    function automatic t_q32 sat32(input logic signed [VW-1:0] v);
        if (v > VW'(64'sh7FFF_FFFF))       sat32 = t_q32'(32'h7FFF_FFFF);
        else if (v < -VW'(64'sh8000_0000)) sat32 = t_q32'(32'h8000_0000);
        else                                sat32 = t_q32'(v[31:0]);
    endfunction

    // (w + 2) * nx and (2 - h) * ny
    assign kx = 16'(i_view_width) + 16'sd2;
    assign ky = 16'sd2 - 16'(i_view_height);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= kx * i_nx;
            r_py <= ky * i_ny;
            r_nx <= i_nx;
            r_ny <= i_ny;
        end
    end

    always_comb begin
        sum_x  = VW'(r_px) + $signed(VW'({i_view_width, FRAC_BITS'(0)}));
        sum_y  = VW'(r_py) + $signed(VW'({i_view_height, FRAC_BITS'(0)}));
        half_x = sum_x >>> 1;
        half_y = sum_y >>> 1;
        by     = 33'(r_ny) + 33'(i_y_bias);
        if (i_mode == MODE_PIXEL) begin
            o_sx = sat32(half_x);
            o_sy = sat32(half_y);
        end else begin
            o_sx = r_nx;
            o_sy = sat32(VW'(by));
        end
    end

endmodule

>>> rtl/world_to_screen_projection.sv
// top level of the world-to-screen projection pipeline
//  channel  dir  carries
//  i_pt     in   op, coef_index, coef_value, pos_x, pos_y, pos_z
//  o_res    out  visible, screen_x, screen_y
//  i_cfg_*  in   register writes, index with data
// one transaction a cycle unless o_res stalls; new points enter before earlier ones leave
// the divider gives one quotient bit per stage over 33 stages
// a load writes the matrix at its acceptance edge and gives no result
// a stall on o_res freezes every stage at once, so nothing is lost or repeated
// reset clears the matrix and all valid bits
module world_to_screen_projection
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    wtsp_pt_if.sink              i_pt,
    wtsp_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);

    localparam int CW   = CLIP_BASE - FRAC_BITS;
    localparam int SIDE = QBITS + 2;

    logic [13:0]        r_view_width;
    logic [13:0]        r_view_height;
    logic [30:0]        r_near_w;
    logic               r_mode;
    logic signed [31:0] r_y_bias;

    logic               en;
    logic               accept;
    logic               mul_valid;
    logic signed [63:0] prod [0:8];
    logic signed [31:0] offs [0:2];
    logic               clip_valid;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cw;
    logic               vis;
    t_q32               nx;
    t_q32               ny;
    t_q32               sx;
    t_q32               sy;

    logic               r_side_valid [0:SIDE-1];
    logic               r_side_vis   [0:SIDE-1];
    logic               r_out_valid;
    logic               r_out_vis;
    t_q32               r_out_x;
    t_q32               r_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_width  <= VIEW_WIDTH_RST;
            r_view_height <= VIEW_HEIGHT_RST;
            r_near_w      <= NEAR_W_RST;
            r_mode        <= OUT_MODE_RST;
            r_y_bias      <= Y_BIAS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_VIEW_WIDTH:  r_view_width  <= i_cfg_data[13:0];
                REG_VIEW_HEIGHT: r_view_height <= i_cfg_data[13:0];
                REG_NEAR_W:      r_near_w      <= i_cfg_data[30:0];
                REG_OUT_MODE:    r_mode        <= i_cfg_data[0];
                REG_Y_BIAS:      r_y_bias      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en          = !r_out_valid || o_res.ready;
    assign i_pt.ready  = en;
    assign accept      = i_pt.valid && en;

    wtsp_matrix u_matrix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_accept     (accept),
        .i_op         (i_pt.op),
        .i_coef_index (i_pt.coef_index),
        .i_coef_value (i_pt.coef_value),
        .i_pos_x      (i_pt.pos_x),
        .i_pos_y      (i_pt.pos_y),
        .i_pos_z      (i_pt.pos_z),
        .o_valid      (mul_valid),
        .o_prod       (prod),
        .o_offs       (offs)
    );

    wtsp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mul_valid),
        .i_prod  (prod),
        .i_offs  (offs),
        .o_valid (clip_valid),
        .o_cx    (cx),
        .o_cy    (cy),
        .o_cw    (cw)
    );

    assign vis = cw >= $signed(CW'(r_near_w));

    wtsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (cx),
        .i_den (cw),
        .o_quo (nx)
    );

    wtsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (cy),
        .i_den (cw),
        .o_quo (ny)
    );

    wtsp_viewport #(.FRAC_BITS(FRAC_BITS)) u_viewport (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_nx          (nx),
        .i_ny          (ny),
        .i_view_width  (r_view_width),
        .i_view_height (r_view_height),
        .i_mode        (r_mode),
        .i_y_bias      (r_y_bias),
        .o_sx          (sx),
        .o_sy          (sy)
    );

    // valid and visible flags ride alongside the divider and viewport stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SIDE; i++) r_side_valid[i] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_side_valid[0] <= clip_valid;
            for (int i = 1; i < SIDE; i++) r_side_valid[i] <= r_side_valid[i-1];
            r_out_valid <= r_side_valid[SIDE-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side_vis[0] <= vis;
            for (int i = 1; i < SIDE; i++) r_side_vis[i] <= r_side_vis[i-1];
            r_out_vis <= r_side_vis[SIDE-1];
            r_out_x   <= r_side_vis[SIDE-1] ? sx : '0;
            r_out_y   <= r_side_vis[SIDE-1] ? sy : '0;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.visible  = r_out_vis;
    assign o_res.screen_x = r_out_x;
    assign o_res.screen_y = r_out_y;

`ifndef SYNTHESIS
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.visible |-> o_res.screen_x == 0 && o_res.screen_y == 0)
        else $error("hidden point with non-zero position");
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_pt.op == OP_LOAD |=> !mul_valid)
        else $error("load transaction entered the pipeline");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_side_valid[SIDE-1]) && $stable(r_out_valid))
        else $error("pipeline moved during a stall");
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");
`endif

endmodule
